### src/two_level_dedup_flush_scheduler_unit_defines.svh
// Assertion macros used by the scheduler checker.
`ifndef TWO_LEVEL_DEDUP_FLUSH_SCHEDULER_UNIT_DEFINES_SVH
`define TWO_LEVEL_DEDUP_FLUSH_SCHEDULER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TDFS_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("scheduler check failed");

// Next-cycle implication, disabled during reset.
`define TDFS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("scheduler check failed");

`endif

### src/tdfs_pkg.sv
// Shared widths, codes and control structs of the flush scheduler.
package tdfs_pkg;

   localparam int ID_W     = 10;
   localparam int CNT_W    = 11;
   localparam int ID_SPACE = 1 << ID_W;

   localparam logic MODE_ENQ   = 1'b0;
   localparam logic MODE_FLUSH = 1'b1;

   // memory write strobes produced by one evaluated word
   typedef struct packed {
      logic hfifo_we;
      logic lfifo_we;
      logic hmem_we;
      logic hmem_bit;
      logic lmem_we;
      logic lmem_bit;
   } wr_cmd_type;

   // result word of one evaluated item
   typedef struct packed {
      logic             inserted;
      logic             picked;
      logic [ID_W-1:0]  picked_id;
      logic             picked_high;
      logic             more_work;
      logic [CNT_W-1:0] high_count;
      logic [CNT_W-1:0] low_count;
   } result_type;

endpackage

### src/tdfs_if.sv
// Request and response channel interfaces of the flush scheduler.
interface tdfs_req_if;
   logic       valid;
   logic       ready;
   logic       mode;
   logic [9:0] bucket_id;
   logic       to_high;

   modport source (output valid, output mode, output bucket_id, output to_high,
                   input ready);
   modport sink   (input valid, input mode, input bucket_id, input to_high,
                   output ready);
endinterface

interface tdfs_rsp_if;
   logic        valid;
   logic        ready;
   logic        inserted;
   logic        picked;
   logic [9:0]  picked_id;
   logic        picked_high;
   logic        more_work;
   logic [10:0] high_count;
   logic [10:0] low_count;

   modport source (output valid, output inserted, output picked, output picked_id,
                   output picked_high, output more_work, output high_count,
                   output low_count, input ready);
   modport sink   (input valid, input inserted, input picked, input picked_id,
                   input picked_high, input more_work, input high_count,
                   input low_count, output ready);
endinterface

### src/two_level_dedup_flush_scheduler_unit.sv
// An accepted word and its RAM reads are registered; its result then enters the response
// register once that is free. The next request word is accepted only after the RAM write-back.
// A waiting response word does not block acceptance of the next request word.
// Reset: synchronous; the membership maps are then swept to zero over all min(NUM_IDS, 1024)
// slots, during which no request word is accepted.
module two_level_dedup_flush_scheduler_unit #(
   parameter int NUM_IDS = 1024
) (
   input logic     clock,
   input logic     reset,
   tdfs_req_if.sink   req_ch,
   tdfs_rsp_if.source rsp_ch
);
   import tdfs_pkg::*;

   localparam int DEPTH  = (NUM_IDS < ID_SPACE) ? NUM_IDS : ID_SPACE;
   localparam int ADDR_W = $clog2(DEPTH);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } state_type;

   state_type         state_ff, state_in;
   logic              clr_busy_ff;
   logic [ADDR_W-1:0] clr_ptr_ff;
   logic              mode_ff, to_high_ff;
   logic [ID_W-1:0]   id_ff;
   logic              rsp_valid_ff;
   result_type        rsp_data_ff;

   logic              accept, go;
   logic [ADDR_W-1:0] high_head, high_tail, low_head, low_tail;
   wr_cmd_type        wr_cmd;
   result_type        result;
   logic              hmem_bit, lmem_bit;
   logic [ID_W-1:0]   hfifo_word, lfifo_word;
   logic [ADDR_W-1:0] hmem_waddr, lmem_waddr;

   assign req_ch.ready = (state_ff == ST_IDLE) && !clr_busy_ff;
   assign accept       = req_ch.valid && req_ch.ready;
   assign go           = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_ch.ready);

   // sequence read then write-back
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (accept) state_in = ST_EXEC;
         ST_EXEC: if (go) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // sweep membership maps after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_ptr_ff  <= '0;
      end else if (clr_busy_ff) begin
         clr_ptr_ff <= clr_ptr_ff + 1'b1;
         if (clr_ptr_ff == ADDR_W'(DEPTH - 1)) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   // hold the accepted word
   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff    <= req_ch.mode;
         id_ff      <= req_ch.bucket_id;
         to_high_ff <= req_ch.to_high;
      end
   end

   // membership write addresses: cleared slot, pushed id or popped id
   always_comb begin
      if (clr_busy_ff) begin
         hmem_waddr = clr_ptr_ff;
         lmem_waddr = clr_ptr_ff;
      end else if (mode_ff == MODE_ENQ) begin
         hmem_waddr = id_ff[ADDR_W-1:0];
         lmem_waddr = id_ff[ADDR_W-1:0];
      end else begin
         hmem_waddr = hfifo_word[ADDR_W-1:0];
         lmem_waddr = lfifo_word[ADDR_W-1:0];
      end
   end

   tdfs_ram #(.WIDTH(ID_W), .DEPTH(DEPTH)) u_hfifo (
      .clock   (clock),
      .wr_en   (go && wr_cmd.hfifo_we),
      .wr_addr (high_tail),
      .wr_data (id_ff),
      .rd_en   (accept),
      .rd_addr (high_head),
      .rd_data (hfifo_word)
   );

   tdfs_ram #(.WIDTH(ID_W), .DEPTH(DEPTH)) u_lfifo (
      .clock   (clock),
      .wr_en   (go && wr_cmd.lfifo_we),
      .wr_addr (low_tail),
      .wr_data (id_ff),
      .rd_en   (accept),
      .rd_addr (low_head),
      .rd_data (lfifo_word)
   );

   tdfs_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_hmem (
      .clock   (clock),
      .wr_en   (clr_busy_ff || (go && wr_cmd.hmem_we)),
      .wr_addr (hmem_waddr),
      .wr_data (!clr_busy_ff && wr_cmd.hmem_bit),
      .rd_en   (accept),
      .rd_addr (req_ch.bucket_id[ADDR_W-1:0]),
      .rd_data (hmem_bit)
   );

   tdfs_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_lmem (
      .clock   (clock),
      .wr_en   (clr_busy_ff || (go && wr_cmd.lmem_we)),
      .wr_addr (lmem_waddr),
      .wr_data (!clr_busy_ff && wr_cmd.lmem_bit),
      .rd_en   (accept),
      .rd_addr (req_ch.bucket_id[ADDR_W-1:0]),
      .rd_data (lmem_bit)
   );

   tdfs_ctrl #(.NUM_IDS(NUM_IDS)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .go         (go),
      .mode       (mode_ff),
      .bucket_id  (id_ff),
      .to_high    (to_high_ff),
      .hmem_bit   (hmem_bit),
      .lmem_bit   (lmem_bit),
      .hfifo_word (hfifo_word),
      .lfifo_word (lfifo_word),
      .high_head  (high_head),
      .high_tail  (high_tail),
      .low_head   (low_head),
      .low_tail   (low_tail),
      .wr_cmd     (wr_cmd),
      .result     (result)
   );

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.inserted    = rsp_data_ff.inserted;
   assign rsp_ch.picked      = rsp_data_ff.picked;
   assign rsp_ch.picked_id   = rsp_data_ff.picked_id;
   assign rsp_ch.picked_high = rsp_data_ff.picked_high;
   assign rsp_ch.more_work   = rsp_data_ff.more_work;
   assign rsp_ch.high_count  = rsp_data_ff.high_count;
   assign rsp_ch.low_count   = rsp_data_ff.low_count;

endmodule

### src/tdfs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tdfs_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/tdfs_ctrl.sv
// Queue pointers, lengths, burst state and per-word evaluation.
module tdfs_ctrl #(
   parameter int NUM_IDS = 1024,
   localparam int DEPTH  = (NUM_IDS < tdfs_pkg::ID_SPACE) ? NUM_IDS : tdfs_pkg::ID_SPACE,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      go,
   input  logic                      mode,
   input  logic [tdfs_pkg::ID_W-1:0] bucket_id,
   input  logic                      to_high,
   input  logic                      hmem_bit,
   input  logic                      lmem_bit,
   input  logic [tdfs_pkg::ID_W-1:0] hfifo_word,
   input  logic [tdfs_pkg::ID_W-1:0] lfifo_word,
   output logic [ADDR_W-1:0]         high_head,
   output logic [ADDR_W-1:0]         high_tail,
   output logic [ADDR_W-1:0]         low_head,
   output logic [ADDR_W-1:0]         low_tail,
   output tdfs_pkg::wr_cmd_type      wr_cmd,
   output tdfs_pkg::result_type      result
);
   import tdfs_pkg::*;

   localparam int LEN_W = $clog2(DEPTH + 1);

   logic [ADDR_W-1:0] hhead_ff, hhead_in, htail_ff, htail_in;
   logic [ADDR_W-1:0] lhead_ff, lhead_in, ltail_ff, ltail_in;
   logic [LEN_W-1:0]  hlen_ff, hlen_in, llen_ff, llen_in;
   logic [LEN_W-1:0]  budget_ff, budget_in;
   logic              burst_ff, burst_in;
   logic              in_range;
   logic              burst_now;

   function automatic logic [ADDR_W-1:0] step_ptr(input logic [ADDR_W-1:0] p);
      return (p == ADDR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign in_range  = (int'(bucket_id) < NUM_IDS);
   assign burst_now = burst_ff && !(hlen_ff == '0 && llen_ff == '0);

   // evaluate one word: push unique or pick next id
   always_comb begin
      hhead_in  = hhead_ff;
      htail_in  = htail_ff;
      lhead_in  = lhead_ff;
      ltail_in  = ltail_ff;
      hlen_in   = hlen_ff;
      llen_in   = llen_ff;
      budget_in = budget_ff;
      burst_in  = burst_ff;
      wr_cmd    = '0;
      result    = '0;
      if (mode == MODE_ENQ) begin
         if (to_high) begin
            if (in_range && !hmem_bit && hlen_ff != LEN_W'(DEPTH)) begin
               result.inserted = 1'b1;
               wr_cmd.hfifo_we = 1'b1;
               wr_cmd.hmem_we  = 1'b1;
               wr_cmd.hmem_bit = 1'b1;
               htail_in        = step_ptr(htail_ff);
               hlen_in         = hlen_ff + 1'b1;
            end
         end else begin
            if (in_range && !lmem_bit && llen_ff != LEN_W'(DEPTH)) begin
               result.inserted = 1'b1;
               wr_cmd.lfifo_we = 1'b1;
               wr_cmd.lmem_we  = 1'b1;
               wr_cmd.lmem_bit = 1'b1;
               ltail_in        = step_ptr(ltail_ff);
               llen_in         = llen_ff + 1'b1;
            end
         end
      end else begin
         if (hlen_ff != '0) begin
            // start a burst if none runs, then take from high
            if (!burst_now) begin
               budget_in = hlen_ff;
            end
            burst_in           = 1'b1;
            hhead_in           = step_ptr(hhead_ff);
            hlen_in            = hlen_ff - 1'b1;
            wr_cmd.hmem_we     = 1'b1;
            result.picked      = 1'b1;
            result.picked_id   = hfifo_word;
            result.picked_high = 1'b1;
            result.more_work   = (llen_ff != '0);
         end else begin
            // count the budget down, then serve low
            burst_in = burst_now;
            if (burst_now) begin
               budget_in = budget_ff - 1'b1;
               if (budget_ff == LEN_W'(1)) begin
                  burst_in = 1'b0;
               end
            end
            if (llen_ff != '0) begin
               lhead_in         = step_ptr(lhead_ff);
               llen_in          = llen_ff - 1'b1;
               wr_cmd.lmem_we   = 1'b1;
               result.picked    = 1'b1;
               result.picked_id = lfifo_word;
               result.more_work = 1'b1;
            end
         end
      end
      result.high_count = CNT_W'(hlen_in);
      result.low_count  = CNT_W'(llen_in);
   end

   // advance queue state when the word is committed
   always_ff @(posedge clock) begin
      if (reset) begin
         hhead_ff  <= '0;
         htail_ff  <= '0;
         lhead_ff  <= '0;
         ltail_ff  <= '0;
         hlen_ff   <= '0;
         llen_ff   <= '0;
         budget_ff <= '0;
         burst_ff  <= 1'b0;
      end else if (go) begin
         hhead_ff  <= hhead_in;
         htail_ff  <= htail_in;
         lhead_ff  <= lhead_in;
         ltail_ff  <= ltail_in;
         hlen_ff   <= hlen_in;
         llen_ff   <= llen_in;
         budget_ff <= budget_in;
         burst_ff  <= burst_in;
      end
   end

   assign high_head = hhead_ff;
   assign high_tail = htail_ff;
   assign low_head  = lhead_ff;
   assign low_tail  = ltail_ff;

endmodule

### src/tdfs_checker.sv
// Port-level checks of the flush scheduler and their binding.
`include "two_level_dedup_flush_scheduler_unit_defines.svh"

module tdfs_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        inserted,
   input logic        picked,
   input logic [9:0]  picked_id,
   input logic        picked_high,
   input logic        more_work,
   input logic [10:0] high_count,
   input logic [10:0] low_count
);

   // stalled response word holds
   `TDFS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(picked_id) && $stable(high_count) && $stable(low_count))

   // nothing picked: pick fields are zero
   `TDFS_ASSERT_IMPLY(a_no_pick_zero, clock, reset, rsp_valid && !picked, picked_id == 10'd0 && !picked_high && !more_work)

   // a word either inserts or picks, never both
   `TDFS_ASSERT_IMPLY(a_ins_pick_excl, clock, reset, rsp_valid, !(inserted && picked))

   // a low pick always reports more work
   `TDFS_ASSERT_IMPLY(a_low_more, clock, reset, rsp_valid && picked && !picked_high, more_work)

endmodule

bind two_level_dedup_flush_scheduler_unit tdfs_checker u_tdfs_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .inserted    (rsp_ch.inserted),
   .picked      (rsp_ch.picked),
   .picked_id   (rsp_ch.picked_id),
   .picked_high (rsp_ch.picked_high),
   .more_work   (rsp_ch.more_work),
   .high_count  (rsp_ch.high_count),
   .low_count   (rsp_ch.low_count)
);

### dv/testbench.sv
// Self-checking testbench for the two-level dedup flush scheduler unit.
`timescale 1ns / 100ps

module testbench;
   import tdfs_pkg::*;

   localparam int RESET_CYCLES = 7;
   localparam int HOLD_CYCLES  = 300;
   localparam int QUIET_LIMIT  = 6000;
   localparam int DRAIN_CYCLES = 10;
   localparam int RANDOM_WORDS = 400;
   localparam int OPENING_ROWS = 25;

   // one row of the opening sequence; want is used only where fixed is set
   typedef struct packed {
      logic             mode;
      logic [ID_W-1:0]  bucket_id;
      logic             to_high;
      logic             fixed;
      result_type       want;
   } plan_row_type;

   localparam plan_row_type OPENING_PLAN [OPENING_ROWS] = '{
      '{MODE_FLUSH, 10'd0,    1'b0, 1'b1, '{1'b0, 1'b0, 10'd0, 1'b0, 1'b0, 11'd0, 11'd0}},
      '{MODE_ENQ,   10'd0,    1'b0, 1'b1, '{1'b1, 1'b0, 10'd0, 1'b0, 1'b0, 11'd0, 11'd1}},
      '{MODE_ENQ,   10'd1023, 1'b1, 1'b1, '{1'b1, 1'b0, 10'd0, 1'b0, 1'b0, 11'd1, 11'd1}},
      '{MODE_ENQ,   10'd1023, 1'b1, 1'b1, '{1'b0, 1'b0, 10'd0, 1'b0, 1'b0, 11'd1, 11'd1}},
      '{MODE_ENQ,   10'd1023, 1'b0, 1'b1, '{1'b1, 1'b0, 10'd0, 1'b0, 1'b0, 11'd1, 11'd2}},
      '{MODE_ENQ,   10'd512,  1'b1, 1'b0, '0},
      '{MODE_FLUSH, 10'h155,  1'b1, 1'b0, '0},
      '{MODE_ENQ,   10'd5,    1'b1, 1'b0, '0},
      '{MODE_FLUSH, 10'd1023, 1'b0, 1'b0, '0},
      '{MODE_FLUSH, 10'd0,    1'b0, 1'b0, '0},
      '{MODE_FLUSH, 10'h2AA,  1'b1, 1'b0, '0},
      '{MODE_FLUSH, 10'd0,    1'b0, 1'b0, '0},
      '{MODE_FLUSH, 10'd0,    1'b1, 1'b0, '0},
      '{MODE_ENQ,   10'h2AA,  1'b1, 1'b0, '0},
      '{MODE_ENQ,   10'h155,  1'b1, 1'b0, '0},
      '{MODE_ENQ,   10'h2AA,  1'b0, 1'b0, '0},
      '{MODE_ENQ,   10'd0,    1'b0, 1'b0, '0},
      '{MODE_FLUSH, 10'd1023, 1'b1, 1'b0, '0},
      '{MODE_ENQ,   10'h2AA,  1'b1, 1'b0, '0},
      '{MODE_FLUSH, 10'd0,    1'b0, 1'b0, '0},
      '{MODE_FLUSH, 10'd0,    1'b0, 1'b0, '0},
      '{MODE_FLUSH, 10'd0,    1'b0, 1'b0, '0},
      '{MODE_FLUSH, 10'd0,    1'b0, 1'b0, '0},
      '{MODE_FLUSH, 10'd0,    1'b0, 1'b0, '0},
      '{MODE_FLUSH, 10'd0,    1'b0, 1'b0, '0}
   };

   logic clock = 1'b0;
   logic reset;

   tdfs_req_if req_ch ();
   tdfs_rsp_if rsp_ch ();

   two_level_dedup_flush_scheduler_unit #(.NUM_IDS(ID_SPACE)) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // scheduler shadow state
   logic [ID_W-1:0]  high_ring [ID_SPACE];
   logic [ID_W-1:0]  low_ring  [ID_SPACE];
   bit               high_seen [ID_SPACE];
   bit               low_seen  [ID_SPACE];
   logic [ID_W-1:0]  high_rd, high_wr, low_rd, low_wr;
   logic [CNT_W-1:0] high_len, low_len, burst_left;
   bit               in_burst;

   result_type pending_words [$];
   int         mismatches = 0;
   int         quiet_cycles = 0;
   bit         no_idling = 1'b0;
   bit         hold_req = 1'b0;

   // mostly short gaps, now and then a long one
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [ID_W-1:0] random_id();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return ID_W'($urandom_range(0, 15));
      if (r < 60) begin
         case ($urandom_range(0, 3))
            0: return '0;
            1: return '1;
            2: return 10'h200;
            default: return 10'h1FF;
         endcase
      end
      return ID_W'($urandom_range(0, ID_SPACE - 1));
   endfunction

   // advance the shadow scheduler by one word and return its response
   function automatic result_type schedule_word(logic mode, logic [ID_W-1:0] id,
                                                logic to_high);
      result_type r;
      r = '0;
      if (mode == MODE_ENQ) begin
         if (to_high) begin
            if (!high_seen[id] && high_len < ID_SPACE) begin
               high_seen[id] = 1'b1;
               high_ring[high_wr] = id;
               high_wr = high_wr + 1'b1;
               high_len = high_len + 1'b1;
               r.inserted = 1'b1;
            end
         end else begin
            if (!low_seen[id] && low_len < ID_SPACE) begin
               low_seen[id] = 1'b1;
               low_ring[low_wr] = id;
               low_wr = low_wr + 1'b1;
               low_len = low_len + 1'b1;
               r.inserted = 1'b1;
            end
         end
      end else begin
         if (high_len == 0 && low_len == 0) in_burst = 1'b0;
         // open a burst sized by the current high backlog
         if (!in_burst && high_len != 0) begin
            burst_left = high_len;
            in_burst = 1'b1;
         end
         if (in_burst && high_len != 0) begin
            r.picked = 1'b1;
            r.picked_id = high_ring[high_rd];
            r.picked_high = 1'b1;
            high_seen[r.picked_id] = 1'b0;
            high_rd = high_rd + 1'b1;
            high_len = high_len - 1'b1;
            r.more_work = (low_len != 0);
         end else begin
            // count the burst down while the high queue stays empty
            if (in_burst) begin
               burst_left = burst_left - 1'b1;
               if (burst_left == 0) in_burst = 1'b0;
            end
            if (low_len != 0) begin
               r.picked = 1'b1;
               r.picked_id = low_ring[low_rd];
               low_seen[r.picked_id] = 1'b0;
               low_rd = low_rd + 1'b1;
               low_len = low_len - 1'b1;
               r.more_work = 1'b1;
            end
         end
      end
      r.high_count = high_len;
      r.low_count = low_len;
      return r;
   endfunction

   // offer one request word, hold it until accepted, then record its response
   task automatic send_word(input logic mode, input logic [ID_W-1:0] id,
                            input logic to_high, input logic fixed,
                            input result_type fixed_want);
      int         gap;
      result_type want;
      gap = no_idling ? 0 : gap_len();
      if (gap > 0) begin
         @(negedge clock);
         req_ch.valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_ch.valid = 1'b1;
      req_ch.mode = mode;
      req_ch.bucket_id = id;
      req_ch.to_high = to_high;
      do @(posedge clock); while (!req_ch.ready);
      want = schedule_word(mode, id, to_high);
      pending_words.push_back(fixed ? fixed_want : want);
   endtask

   // drop the request, then hold until every expected word has come back
   task automatic wait_all_done();
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
   endtask

   // response side: random stalls, plus one long hold when asked
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_req) begin
            hold_req = 1'b0;
            rsp_ch.ready = 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
         end else if (stall_left > 0) begin
            rsp_ch.ready = 1'b0;
            stall_left--;
         end else begin
            rsp_ch.ready = 1'b1;
            if (!no_idling) stall_left = gap_len();
         end
      end
   end

   // compare each response word against the oldest expectation
   always @(posedge clock) begin
      result_type got, want;
      if (rsp_ch.valid && rsp_ch.ready) begin
         got.inserted = rsp_ch.inserted;
         got.picked = rsp_ch.picked;
         got.picked_id = rsp_ch.picked_id;
         got.picked_high = rsp_ch.picked_high;
         got.more_work = rsp_ch.more_work;
         got.high_count = rsp_ch.high_count;
         got.low_count = rsp_ch.low_count;
         if (pending_words.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected word: ins=%0d pick=%0d id=%0d high=%0d more=%0d hc=%0d lc=%0d",
                        got.inserted, got.picked, got.picked_id, got.picked_high,
                        got.more_work, got.high_count, got.low_count);
         end else begin
            want = pending_words.pop_front();
            if (got.inserted !== want.inserted || got.picked !== want.picked ||
                got.picked_id !== want.picked_id || got.picked_high !== want.picked_high ||
                got.more_work !== want.more_work || got.high_count !== want.high_count ||
                got.low_count !== want.low_count) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch at %0t", $realtime);
                  $display("  exp: ins=%0d pick=%0d id=%0d high=%0d more=%0d hc=%0d lc=%0d",
                           want.inserted, want.picked, want.picked_id, want.picked_high,
                           want.more_work, want.high_count, want.low_count);
                  $display("  got: ins=%0d pick=%0d id=%0d high=%0d more=%0d hc=%0d lc=%0d",
                           got.inserted, got.picked, got.picked_id, got.picked_high,
                           got.more_work, got.high_count, got.low_count);
               end
            end
         end
      end
   end

   // end the run when no word moves on either channel for too long
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   initial begin
      int flush_pct;
      logic mode;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.mode = MODE_ENQ;
      req_ch.bucket_id = '0;
      req_ch.to_high = 1'b0;
      for (int i = 0; i < ID_SPACE; i++) begin
         high_ring[i] = '0;
         low_ring[i] = '0;
         high_seen[i] = 1'b0;
         low_seen[i] = 1'b0;
      end
      high_rd = '0;
      high_wr = '0;
      low_rd = '0;
      low_wr = '0;
      high_len = '0;
      low_len = '0;
      burst_left = '0;
      in_burst = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // opening sequence: empty flush, duplicates, burst countdown, ignored fields
      for (int i = 0; i < OPENING_ROWS; i++) begin
         send_word(OPENING_PLAN[i].mode, OPENING_PLAN[i].bucket_id, OPENING_PLAN[i].to_high,
                   OPENING_PLAN[i].fixed, OPENING_PLAN[i].want);
      end

      // random traffic in segments of varying flush density
      flush_pct = 40;
      for (int i = 0; i < RANDOM_WORDS; i++) begin
         no_idling = (i < 60);
         if (i % 50 == 0) flush_pct = $urandom_range(20, 70);
         if (i == 150) hold_req = 1'b1;
         if (i == 300) wait_all_done();
         mode = ($urandom_range(0, 99) < flush_pct) ? MODE_FLUSH : MODE_ENQ;
         send_word(mode, random_id(), 1'($urandom_range(0, 1)), 1'b0, '0);
      end

      wait_all_done();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+src
src/tdfs_pkg.sv
src/tdfs_if.sv
src/tdfs_ram.sv
src/tdfs_ctrl.sv
src/two_level_dedup_flush_scheduler_unit.sv
src/tdfs_checker.sv
dv/testbench.sv
